@@ src/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the panel frame builder
// Holds the segment table, the LED bit positions, the blink phase step and
// the frame and item types used between the modules.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int SHORT_BYTES = 2;
  localparam int LED_BYTE    = 8;
  localparam int COLOUR_BYTE = 9;

  localparam logic [7:0] SEG_POINT   = 8'h10;
  localparam logic [7:0] SEG_BLANK   = 8'h00;
  localparam logic [7:0] LED_ACTUAL  = 8'h80;
  localparam logic [7:0] LED_SETPT   = 8'h40;
  localparam logic [7:0] LED_CC      = 8'h20;
  localparam logic [7:0] LED_PS      = 8'h08;
  localparam logic [7:0] LED_CV      = 8'h04;
  localparam logic [7:0] LED_OVERTMP = 8'h80;
  localparam logic [7:0] LED_FAIL    = 8'h40;

  localparam logic [1:0] COLOUR_RED    = 2'd1;
  localparam logic [1:0] COLOUR_YELLOW = 2'd3;
  localparam logic [1:0] BLINK_LAST    = 2'd2;

  typedef struct packed {
    logic [31:0] current_chars;
    logic [31:0] voltage_chars;
    logic        current_point;
    logic        voltage_point;
    logic [9:0]  status_leds;
    logic [1:0]  overtemp_led;
    logic [1:0]  fail_led;
    logic [1:0]  disable_led;
    logic [1:0]  remote_led;
  } item_t;

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic                        short_mode;
  } frame_t;

  // Map one ASCII character to its segment byte (a b c dp d e f g, MSB first).
  function automatic logic [7:0] seg_of(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      "0":     s = 8'hEE;
      "1":     s = 8'h60;
      "2":     s = 8'hCD;
      "3":     s = 8'hE9;
      "4":     s = 8'h63;
      "5":     s = 8'hAB;
      "6":     s = 8'hAF;
      "7":     s = 8'hE0;
      "8":     s = 8'hEF;
      "9":     s = 8'hEB;
      "A":     s = 8'hE7;
      "C":     s = 8'h8E;
      "E":     s = 8'h8F;
      "F":     s = 8'h87;
      "H":     s = 8'h67;
      "L":     s = 8'h0E;
      "P":     s = 8'hC7;
      "S":     s = 8'hAB;
      "U":     s = 8'h6E;
      "d":     s = 8'h6D;
      "r":     s = 8'h05;
      "t":     s = 8'h0F;
      "-":     s = 8'h01;
      ".":     s = 8'h10;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Blink phase counts 0, 1, 2 and wraps.
  function automatic logic [1:0] blink_inc(input logic [1:0] p);
    return (p >= BLINK_LAST) ? 2'd0 : p + 2'd1;
  endfunction

  // Yellow dims to red except on phase 0.
  function automatic logic [1:0] led_colour(input logic [1:0] s, input logic [1:0] p);
    return (s == COLOUR_YELLOW && p != 2'd0) ? COLOUR_RED : s;
  endfunction

endpackage

@@ src/ssp_encode.sv @@
// ----------------------------------------------------------------------------
// ssp_encode: frame encoder with blink phase
// Turns one held item into the ten frame bytes and advances the blink phase
// by the number of colour encodings when the frame is taken.
// ----------------------------------------------------------------------------
module ssp_encode (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           short_mode,
  input  ssp_pkg::item_t item,
  output ssp_pkg::frame_t frame
);
  import ssp_pkg::*;

  logic [1:0] blink_phase;
  logic [1:0] blink_phase_next;
  logic [1:0] p1, p2, p3, p4;
  logic [7:0] b8, b9;

  assign p1 = blink_inc(blink_phase);
  assign p2 = blink_inc(p1);
  assign p3 = blink_inc(p2);
  assign p4 = blink_inc(p3);

  assign blink_phase_next = short_mode ? p4 : p2;

  always_comb begin
    b8 = 8'h00;
    if (item.status_leds[1:0] != 2'd0) b8 = b8 | LED_ACTUAL;
    if (item.status_leds[3:2] != 2'd0) b8 = b8 | LED_SETPT;
    if (item.status_leds[5:4] != 2'd0) b8 = b8 | LED_CC;
    if (item.status_leds[7:6] != 2'd0) b8 = b8 | LED_PS;
    if (item.status_leds[9:8] != 2'd0) b8 = b8 | LED_CV;
  end

  always_comb begin
    if (short_mode) begin
      b9 = {led_colour(item.overtemp_led, p1), led_colour(item.fail_led, p2),
            led_colour(item.disable_led, p3), led_colour(item.remote_led, p4)};
    end else begin
      b9 = {4'h0, led_colour(item.disable_led, p1), led_colour(item.remote_led, p2)}
           << 2;
      if (item.overtemp_led != 2'd0) b9 = b9 | LED_OVERTMP;
      if (item.fail_led != 2'd0)     b9 = b9 | LED_FAIL;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      frame.bytes[i]     = seg_of(item.current_chars[8*i +: 8]);
      frame.bytes[4 + i] = seg_of(item.voltage_chars[8*i +: 8]);
    end
    if (item.current_point) frame.bytes[1] = frame.bytes[1] | SEG_POINT;
    if (item.voltage_point) frame.bytes[5] = frame.bytes[5] | SEG_POINT;
    frame.bytes[LED_BYTE]    = b8;
    frame.bytes[COLOUR_BYTE] = b9;
    frame.short_mode         = short_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_phase <= 2'd0;
    end else if (advance) begin
      blink_phase <= blink_phase_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    blink_phase != 2'd3)
    else $error("blink phase left its 0..2 range");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(blink_phase))
    else $error("blink phase moved without a frame load");

  a_phase_short: assert property (@(posedge clk) disable iff (rst)
    advance && short_mode |=> blink_phase == blink_inc($past(blink_phase)))
    else $error("short frame did not advance the phase by four");

endmodule

@@ src/ssp_serializer.sv @@
// ----------------------------------------------------------------------------
// ssp_serializer: frame shift register and output stage
// Loads a built frame and sends it out one byte per transfer, flagging the
// final byte; reports when the next frame may be loaded.
// ----------------------------------------------------------------------------
module ssp_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ssp_pkg::frame_t frame,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      frame_byte,
  output logic            last_byte
);
  import ssp_pkg::*;

  logic [FRAME_BYTES-1:0][7:0] shift;
  logic [FRAME_BYTES-1:0][7:0] shift_next;
  logic [CNT_W-1:0]            remain;
  logic [CNT_W-1:0]            remain_next;
  logic                        xfer;

  assign out_valid  = (remain != '0);
  assign frame_byte = shift[0];
  assign last_byte  = (remain == CNT_W'(1));
  assign xfer       = out_valid && out_ready;
  assign can_load   = !out_valid || (xfer && last_byte);

  always_comb begin
    shift_next  = shift;
    remain_next = remain;
    if (load) begin
      if (frame.short_mode) begin
        shift_next    = '0;
        shift_next[0] = frame.bytes[LED_BYTE];
        shift_next[1] = frame.bytes[COLOUR_BYTE];
        remain_next   = CNT_W'(SHORT_BYTES);
      end else begin
        shift_next  = frame.bytes;
        remain_next = CNT_W'(FRAME_BYTES);
      end
    end else if (xfer) begin
      shift_next  = {8'h00, shift[FRAME_BYTES-1:1]};
      remain_next = remain - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    shift <= shift_next;
    if (rst) begin
      remain <= '0;
    end else begin
      remain <= remain_next;
    end
  end

  a_remain_range: assert property (@(posedge clk) disable iff (rst)
    remain <= CNT_W'(FRAME_BYTES))
    else $error("byte count above frame length");

  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("frame loaded over bytes still to send");

  a_load_len: assert property (@(posedge clk) disable iff (rst)
    load && frame.short_mode |=> remain == CNT_W'(SHORT_BYTES))
    else $error("short frame loaded with wrong length");

endmodule

@@ src/seven_segment_panel_frame_builder_core.sv @@
// ----------------------------------------------------------------------------
// seven_segment_panel_frame_builder_core: panel update to display frame
// Holds one update, encodes it into segment and LED bytes and streams the
// frame out byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one panel update: eight digit
//   characters, two decimal point flags and the LED states. Output channel
//   (out_valid/out_ready) carries the frame bytes in send order; last_byte
//   marks the final byte of each frame. The configuration channel
//   (cfg_valid/cfg_ready/cfg_data) writes short_frame_mode and is always
//   ready; the user writes it only while the block is idle (not enforced).
//   An accepted update is held in the input register, then loads into the
//   frame shift register, the limit on throughput: one byte per cycle while
//   out_ready is high, ten bytes per update in normal mode and two in short
//   mode. A second update is held in the input register while the current
//   frame drains, and its frame loads on the cycle the last byte transfers.
//   When the receiver stalls, the current byte holds and the input register
//   fills, after which in_ready drops. Reset empties both stages, clears
//   the blink phase and selects the ten-byte frame.
// ----------------------------------------------------------------------------
module seven_segment_panel_frame_builder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] current_chars,
  input  logic [31:0] voltage_chars,
  input  logic        current_point,
  input  logic        voltage_point,
  input  logic [9:0]  status_leds,
  input  logic [1:0]  overtemp_led,
  input  logic [1:0]  fail_led,
  input  logic [1:0]  disable_led,
  input  logic [1:0]  remote_led,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        last_byte
);
  import ssp_pkg::*;

  logic   short_frame_mode;
  logic   in_full;
  logic   in_full_next;
  item_t  item;
  frame_t frame;
  logic   can_load;
  logic   load;
  logic   in_xfer;

  // Configuration: always take the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_frame_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      short_frame_mode <= cfg_data;
    end
  end

  // Input register: take a new update when empty or when the held one
  // moves into the serializer in the same cycle.
  assign load     = in_full && can_load;
  assign in_ready = !in_full || load;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    in_full_next = in_full;
    if (in_xfer) begin
      in_full_next = 1'b1;
    end else if (load) begin
      in_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= '{current_chars: current_chars, voltage_chars: voltage_chars,
                current_point: current_point, voltage_point: voltage_point,
                status_leds: status_leds, overtemp_led: overtemp_led,
                fail_led: fail_led, disable_led: disable_led,
                remote_led: remote_led};
    end
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  // Encode the held update; the blink phase advances as its frame loads.
  ssp_encode u_encode (
    .clk        (clk),
    .rst        (rst),
    .advance    (load),
    .short_mode (short_frame_mode),
    .item       (item),
    .frame      (frame)
  );

  // Drain the frame one byte per transfer.
  ssp_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .frame      (frame),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_full && !load |=> in_full)
    else $error("held update dropped before its frame loaded");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    in_full && !out_valid |-> load)
    else $error("serializer idle while an update waits");

  a_last_then_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_byte && in_full |=> out_valid)
    else $error("queued frame not loaded after last byte");

endmodule

@@ test/tb_seven_segment_panel_frame_builder_core.sv @@
// ----------------------------------------------------------------------------
// tb_seven_segment_panel_frame_builder_core: self-checking frame builder test
// Feeds panel updates through the input channel, predicts every frame byte
// (segment lookup, decimal points, LED packing and the blink phase) and
// compares each output transfer against the oldest predicted byte. Runs
// directed updates in both frame modes, then random updates across several
// mode settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_seven_segment_panel_frame_builder_core;
  import ssp_pkg::*;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 24;    // quiet tail after the last byte

  // Byte that the frame builder is expected to send, with its end marker.
  typedef struct packed {
    logic [7:0] seg;
    logic       last;
  } panel_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;
  logic cfg_ready;

  logic  in_valid   = 1'b0;
  item_t drive_item = '0;
  logic  in_ready;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       last_byte;

  // Predictor state: mirrored frame mode and blink phase.
  logic       short_mode  = 1'b0;
  logic [1:0] blink_phase = 2'd0;

  item_t       pending_updates[$];
  panel_byte_t bytes_due[$];
  int          updates_left = 0;

  // Transfer flags, set at the rising edge and read at the falling edge.
  bit in_xfer  = 1'b0;
  bit out_xfer = 1'b0;
  bit cfg_xfer = 1'b0;

  int in_gap    = 0;
  int out_stall = 0;
  bit in_calm   = 1'b0;
  bit out_calm  = 1'b0;

  int          idle_cycles = 0;
  int          mismatches  = 0;
  int          bytes_seen  = 0;
  panel_byte_t due;

  string glyph_chars = "0123456789ACEFHLPSUdrt-.";

  seven_segment_panel_frame_builder_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .current_chars(drive_item.current_chars),
    .voltage_chars(drive_item.voltage_chars),
    .current_point(drive_item.current_point),
    .voltage_point(drive_item.voltage_point),
    .status_leds  (drive_item.status_leds),
    .overtemp_led (drive_item.overtemp_led),
    .fail_led     (drive_item.fail_led),
    .disable_led  (drive_item.disable_led),
    .remote_led   (drive_item.remote_led),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Segment pattern of one display character, blank for anything unknown.
  function automatic logic [7:0] segment_pattern(input logic [7:0] c);
    case (c)
      "0": return 8'hEE;
      "1": return 8'h60;
      "2": return 8'hCD;
      "3": return 8'hE9;
      "4": return 8'h63;
      "5", "S": return 8'hAB;
      "6": return 8'hAF;
      "7": return 8'hE0;
      "8": return 8'hEF;
      "9": return 8'hEB;
      "A": return 8'hE7;
      "C": return 8'h8E;
      "E": return 8'h8F;
      "F": return 8'h87;
      "H": return 8'h67;
      "L": return 8'h0E;
      "P": return 8'hC7;
      "U": return 8'h6E;
      "d": return 8'h6D;
      "r": return 8'h05;
      "t": return 8'h0F;
      "-": return 8'h01;
      ".": return SEG_POINT;
      default: return SEG_BLANK;
    endcase
  endfunction

  // Advance the blink phase, then dim yellow to red unless the phase is 0.
  function automatic logic [1:0] dim_colour(input logic [1:0] led);
    blink_phase = (blink_phase >= 2'd2) ? 2'd0 : blink_phase + 2'd1;
    return (led == COLOUR_YELLOW && blink_phase != 2'd0) ? COLOUR_RED : led;
  endfunction

  // Build the frame for one accepted update and queue the bytes it sends.
  task automatic predict_frame(input item_t u);
    logic [7:0] frame [FRAME_BYTES];
    logic [7:0] led_flags;
    logic [7:0] led_colours;
    int         first;
    for (int i = 0; i < 4; i++) begin
      frame[i]     = segment_pattern(u.current_chars[8*i +: 8]);
      frame[4 + i] = segment_pattern(u.voltage_chars[8*i +: 8]);
    end
    if (u.current_point) frame[1] |= SEG_POINT;
    if (u.voltage_point) frame[5] |= SEG_POINT;

    led_flags = 8'h00;
    if (|u.status_leds[1:0]) led_flags |= LED_ACTUAL;
    if (|u.status_leds[3:2]) led_flags |= LED_SETPT;
    if (|u.status_leds[5:4]) led_flags |= LED_CC;
    if (|u.status_leds[7:6]) led_flags |= LED_PS;
    if (|u.status_leds[9:8]) led_flags |= LED_CV;

    // Keep the encoding order fixed: it decides which LED sees which phase.
    led_colours = 8'h00;
    if (short_mode) begin
      led_colours[7:6] = dim_colour(u.overtemp_led);
      led_colours[5:4] = dim_colour(u.fail_led);
      led_colours[3:2] = dim_colour(u.disable_led);
      led_colours[1:0] = dim_colour(u.remote_led);
      first = LED_BYTE;
    end else begin
      if (|u.overtemp_led) led_colours |= LED_OVERTMP;
      if (|u.fail_led)     led_colours |= LED_FAIL;
      led_colours[5:4] = dim_colour(u.disable_led);
      led_colours[3:2] = dim_colour(u.remote_led);
      first = 0;
    end
    frame[LED_BYTE]    = led_flags;
    frame[COLOUR_BYTE] = led_colours;

    for (int i = first; i < FRAME_BYTES; i++)
      bytes_due.push_back('{seg: frame[i], last: (i == FRAME_BYTES - 1)});
  endtask

  // Wait length for one transfer; flip now and then into a run with no waits.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Mostly real display characters, the rest any byte at all.
  function automatic logic [7:0] random_char();
    if ($urandom_range(0, 3) != 0)
      return glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t random_update();
    item_t u;
    for (int i = 0; i < 4; i++) begin
      u.current_chars[8*i +: 8] = random_char();
      u.voltage_chars[8*i +: 8] = random_char();
    end
    u.current_point = 1'($urandom_range(0, 1));
    u.voltage_point = 1'($urandom_range(0, 1));
    // Sparse patterns show each status bit on its own.
    u.status_leds = ($urandom_range(0, 3) == 0) ? 10'(1 << $urandom_range(0, 9))
                                                : 10'($urandom_range(0, 1023));
    u.overtemp_led = 2'($urandom_range(0, 3));
    u.fail_led     = 2'($urandom_range(0, 3));
    u.disable_led  = 2'($urandom_range(0, 3));
    u.remote_led   = 2'($urandom_range(0, 3));
    return u;
  endfunction

  function automatic item_t make_update(input logic [31:0] cur, input logic [31:0] vol,
                                        input logic cp, input logic vp,
                                        input logic [9:0] st,
                                        input logic [1:0] ot, input logic [1:0] fl,
                                        input logic [1:0] ds, input logic [1:0] rm);
    return '{current_chars: cur, voltage_chars: vol, current_point: cp,
             voltage_point: vp, status_leds: st, overtemp_led: ot,
             fail_led: fl, disable_led: ds, remote_led: rm};
  endfunction

  task automatic queue_update(input item_t u);
    pending_updates.push_back(u);
    updates_left++;
  endtask

  // Drain everything in flight, then write the frame mode.
  task automatic set_frame_mode(input logic mode);
    do @(negedge clk); while (updates_left != 0 || bytes_due.size() != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: present the next pending update, holding it until transfer.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (in_xfer) in_gap = draw_wait(in_calm);
      if (in_gap > 0 || pending_updates.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        drive_item <= pending_updates.pop_front();
        in_valid   <= 1'b1;
      end
    end
  end

  // Output receiver: stall a random number of cycles after each byte.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_xfer) out_stall = draw_wait(out_calm);
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: track mode writes, predict on input transfers, check output
  // transfers against the oldest predicted byte, and watch for a hang.
  always @(posedge clk) begin
    in_xfer  = 1'b0;
    out_xfer = 1'b0;
    cfg_xfer = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_xfer   = 1'b1;
        short_mode = cfg_data;
      end
      if (in_valid && in_ready) begin
        in_xfer = 1'b1;
        predict_frame(drive_item);
        updates_left--;
      end
      if (out_valid && out_ready) begin
        out_xfer = 1'b1;
        if (bytes_due.size() == 0) begin
          $display("%0t: byte %0d expected none, got frame_byte %02h last_byte %0b",
                   $time, bytes_seen, frame_byte, last_byte);
          mismatches++;
        end else begin
          due = bytes_due.pop_front();
          if (frame_byte !== due.seg) begin
            $display("%0t: byte %0d frame_byte expected %02h, got %02h",
                     $time, bytes_seen, due.seg, frame_byte);
            mismatches++;
          end
          if (last_byte !== due.last) begin
            $display("%0t: byte %0d last_byte expected %0b, got %0b",
                     $time, bytes_seen, due.last, last_byte);
            mismatches++;
          end
        end
        bytes_seen++;
      end
      if (in_xfer || out_xfer || cfg_xfer) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("seven_segment_panel_frame_builder_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Ten-byte frames: every table character, unknown bytes at both ends of
    // the range, both decimal points, each status pair, every LED state.
    // Runs of yellow walk the blink phase through all three values.
    set_frame_mode(1'b0);
    queue_update(make_update("0123", "4567", 0, 0, 10'h000, 0, 0, 0, 0));
    queue_update(make_update("89AC", "EFHL", 1, 0, 10'h001, 1, 1, 1, 1));
    queue_update(make_update("PSUd", "rt-.", 0, 1, 10'h008, 2, 2, 2, 2));
    queue_update(make_update(32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 10'h020, 3, 3, 3, 3));
    queue_update(make_update("Bax~", "9 }#", 0, 0, 10'h080, 3, 3, 3, 3));
    queue_update(make_update("8888", "....", 1, 1, 10'h200, 0, 3, 3, 0));
    queue_update(make_update("----", "7F00", 1, 0, 10'h3FF, 3, 0, 0, 3));
    queue_update(make_update(32'h8080_7F7F, 32'h2F3A_4060, 0, 1, 10'h2AA, 1, 2, 3, 3));
    queue_update(make_update("b0e1", "HELP", 1, 1, 10'h155, 2, 1, 3, 2));

    // Two-byte frames: four colour encodings per update, digits ignored.
    set_frame_mode(1'b1);
    queue_update(make_update("1234", "5678", 1, 1, 10'h000, 3, 3, 3, 3));
    queue_update(make_update(32'hFFFF_FFFF, 32'h0, 0, 0, 10'h3FF, 3, 3, 3, 3));
    queue_update(make_update("----", "----", 1, 0, 10'h003, 3, 3, 3, 3));
    queue_update(make_update("0000", "0000", 0, 1, 10'h0C0, 0, 1, 2, 3));
    queue_update(make_update("AAAA", "CCCC", 0, 0, 10'h300, 3, 2, 1, 0));
    queue_update(make_update("rtdU", "SPLH", 1, 1, 10'h00C, 1, 3, 0, 3));
    queue_update(make_update("9999", "9999", 0, 0, 10'h030, 2, 0, 3, 1));

    // Random updates across both modes, the same mode written twice in a row
    // once to show a rewrite changes nothing.
    set_frame_mode(1'b0);
    repeat (100) queue_update(random_update());
    set_frame_mode(1'b1);
    repeat (90) queue_update(random_update());
    set_frame_mode(1'b1);
    repeat (60) queue_update(random_update());
    set_frame_mode(1'b0);
    repeat (120) queue_update(random_update());

    do @(negedge clk); while (updates_left != 0 || bytes_due.size() != 0);
    // Catch any stray byte after the last frame.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("seven_segment_panel_frame_builder_core regression: pass");
    end else begin
      $display("seven_segment_panel_frame_builder_core regression: fail");
    end
    $finish;
  end

endmodule
